>>> design/srbb_pkg.sv
package srbb_pkg;

  // Field widths
  localparam int COORD_BITS     = 24;
  localparam int WIDTH_BITS     = COORD_BITS - 1;
  localparam int ANGLE_BITS     = 9;
  localparam int TRIG_FRAC_BITS = 16;

  // Q1.F sine/cosine, range [-1, +1] inclusive
  localparam int SIN_W  = TRIG_FRAC_BITS + 2;
  // Raw product, rounded product, two-term sum
  localparam int PROD_W = COORD_BITS + SIN_W;
  localparam int RND_W  = COORD_BITS + 1;
  localparam int SUM_W  = COORD_BITS + 2;

  // Angles in whole degrees
  localparam int QUARTER_TURN       = 90;
  localparam int HALF_TURN          = 180;
  localparam int THREE_QUARTER_TURN = 270;
  localparam int FULL_TURN          = 360;
  localparam int QIDX_W             = $clog2(QUARTER_TURN + 1);

  // Register stages from the input to the output register
  localparam int PIPE_DEPTH = 8;

  // pi in unsigned Q2.62, and one degree as quotient and remainder of pi / 180
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] DEG_Q62 = PI_Q62 / HALF_TURN;
  localparam logic [63:0] DEG_R62 = PI_Q62 % HALF_TURN;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [ANGLE_BITS-1:0]        align_angle;
    logic [ANGLE_BITS-1:0]        view_angle;
    logic [WIDTH_BITS-1:0]        left_width;
    logic [WIDTH_BITS-1:0]        right_width;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
  } out_item_t;

  // Stage enables of one rotation unit
  typedef struct packed {
    logic mul;
    logic rnd;
    logic sum;
  } rot_en_t;

  // Quarter-wave sine table, entry k = sin(k degrees)
  typedef logic [QUARTER_TURN:0][SIN_W-1:0] sine_tab_t;

  // Saturation bounds in the sum width
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    if (v > SAT_HI) begin
      return SAT_HI[COORD_BITS-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // (a*b) >> 62 for unsigned Q2.62 operands, elaboration use only
  function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sin(k degrees), k in 0..90, Q1.F rounded; Taylor series in Q2.62.
  // Only evaluated at elaboration to build the quarter-wave table.
  function automatic logic signed [SIN_W-1:0] sin_first(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = DEG_Q62 * 64'(k) + (DEG_R62 * 64'(k)) / HALF_TURN;
    x2   = mulq62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 14; n++) begin
      term = mulq62(term, x2) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = sum + (64'd1 << (61 - TRIG_FRAC_BITS));
    sum = sum >> (62 - TRIG_FRAC_BITS);
    return sum[SIN_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k <= QUARTER_TURN; k++) begin
      t[k] = sin_first(k);
    end
    return t;
  endfunction

  localparam sine_tab_t QUARTER_SINE = build_sine_tab();

endpackage

>>> design/srbb_trig.sv
module srbb_trig import srbb_pkg::*; (
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output logic signed [SIN_W-1:0] sin_o,
  output logic signed [SIN_W-1:0] cos_o
);

  localparam logic [ANGLE_BITS-1:0] A90  = ANGLE_BITS'(QUARTER_TURN);
  localparam logic [ANGLE_BITS-1:0] A180 = ANGLE_BITS'(HALF_TURN);
  localparam logic [ANGLE_BITS-1:0] A270 = ANGLE_BITS'(THREE_QUARTER_TURN);
  localparam logic [ANGLE_BITS-1:0] A360 = ANGLE_BITS'(FULL_TURN);

  // Quarter-wave sine table, constant
  logic signed [SIN_W-1:0] quarter [0:QUARTER_TURN];

  for (genvar k = 0; k <= QUARTER_TURN; k++) begin : g_tab
    assign quarter[k] = QUARTER_SINE[k];
  end

  logic [ANGLE_BITS-1:0] deg;
  logic [ANGLE_BITS-1:0] s_ang;
  logic [ANGLE_BITS-1:0] c_ang;
  logic [QIDX_W-1:0]     s_idx;
  logic [QIDX_W-1:0]     c_idx;
  logic                  s_neg;
  logic                  c_neg;

  // Reduce modulo 360, then fold into the first quadrant
  always_comb begin
    deg = (angle_i >= A360) ? angle_i - A360 : angle_i;
    if (deg <= A90) begin
      s_ang = deg;
      s_neg = 1'b0;
      c_ang = A90 - deg;
      c_neg = 1'b0;
    end else if (deg <= A180) begin
      s_ang = A180 - deg;
      s_neg = 1'b0;
      c_ang = deg - A90;
      c_neg = 1'b1;
    end else if (deg <= A270) begin
      s_ang = deg - A180;
      s_neg = 1'b1;
      c_ang = A270 - deg;
      c_neg = 1'b1;
    end else begin
      s_ang = A360 - deg;
      s_neg = 1'b1;
      c_ang = deg - A270;
      c_neg = 1'b0;
    end
    s_idx = s_ang[QIDX_W-1:0];
    c_idx = c_ang[QIDX_W-1:0];
    sin_o = s_neg ? -quarter[s_idx] : quarter[s_idx];
    cos_o = c_neg ? -quarter[c_idx] : quarter[c_idx];
  end

endmodule

>>> design/srbb_rot.sv
module srbb_rot import srbb_pkg::*; (
  input  logic                    clk,
  input  rot_en_t                 en,
  input  point_t                  p0_i,
  input  point_t                  p1_i,
  input  logic signed [SIN_W-1:0] sin_i,
  input  logic signed [SIN_W-1:0] cos_i,
  output point_t                  c0_o,
  output point_t                  c1_o,
  output point_t                  c2_o,
  output point_t                  c3_o
);

  // Corners: c0 = (x0,y0), c1 = (x1,y0), c2 = (x1,y1), c3 = (x0,y1)
  // Rotation by minus the angle: x' = c*x + s*y, y' = c*y - s*x

  typedef struct packed {
    logic signed [PROD_W-1:0] cx0;
    logic signed [PROD_W-1:0] sx0;
    logic signed [PROD_W-1:0] cx1;
    logic signed [PROD_W-1:0] sx1;
    logic signed [PROD_W-1:0] cy0;
    logic signed [PROD_W-1:0] sy0;
    logic signed [PROD_W-1:0] cy1;
    logic signed [PROD_W-1:0] sy1;
  } prod_t;

  typedef struct packed {
    logic signed [RND_W-1:0] cx0;
    logic signed [RND_W-1:0] sx0;
    logic signed [RND_W-1:0] cx1;
    logic signed [RND_W-1:0] sx1;
    logic signed [RND_W-1:0] cy0;
    logic signed [RND_W-1:0] sy0;
    logic signed [RND_W-1:0] cy1;
    logic signed [RND_W-1:0] sy1;
  } rnd_t;

  localparam logic signed [PROD_W-1:0] RND_HALF    = PROD_W'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RND_HALF_M1 = RND_HALF - PROD_W'(1);

  // Round to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] m);
    logic signed [PROD_W-1:0] t;
    t = m + (m[PROD_W-1] ? RND_HALF_M1 : RND_HALF);
    t = t >>> TRIG_FRAC_BITS;
    return t[RND_W-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] add_sat(
    input logic signed [RND_W-1:0] a,
    input logic signed [RND_W-1:0] b
  );
    return sat_coord(SUM_W'(a) + SUM_W'(b));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sub_sat(
    input logic signed [RND_W-1:0] a,
    input logic signed [RND_W-1:0] b
  );
    return sat_coord(SUM_W'(a) - SUM_W'(b));
  endfunction

  prod_t  prod_nxt;
  prod_t  prod_r;
  rnd_t   rnd_nxt;
  rnd_t   rnd_r;
  point_t c0_r;
  point_t c1_r;
  point_t c2_r;
  point_t c3_r;

  // Multiply stage: eight products
  always_comb begin
    prod_nxt.cx0 = PROD_W'(p0_i.x) * PROD_W'(cos_i);
    prod_nxt.sx0 = PROD_W'(p0_i.x) * PROD_W'(sin_i);
    prod_nxt.cx1 = PROD_W'(p1_i.x) * PROD_W'(cos_i);
    prod_nxt.sx1 = PROD_W'(p1_i.x) * PROD_W'(sin_i);
    prod_nxt.cy0 = PROD_W'(p0_i.y) * PROD_W'(cos_i);
    prod_nxt.sy0 = PROD_W'(p0_i.y) * PROD_W'(sin_i);
    prod_nxt.cy1 = PROD_W'(p1_i.y) * PROD_W'(cos_i);
    prod_nxt.sy1 = PROD_W'(p1_i.y) * PROD_W'(sin_i);
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // Rounding stage
  always_comb begin
    rnd_nxt.cx0 = round_q(prod_r.cx0);
    rnd_nxt.sx0 = round_q(prod_r.sx0);
    rnd_nxt.cx1 = round_q(prod_r.cx1);
    rnd_nxt.sx1 = round_q(prod_r.sx1);
    rnd_nxt.cy0 = round_q(prod_r.cy0);
    rnd_nxt.sy0 = round_q(prod_r.sy0);
    rnd_nxt.cy1 = round_q(prod_r.cy1);
    rnd_nxt.sy1 = round_q(prod_r.sy1);
  end

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      rnd_r <= rnd_nxt;
    end
  end

  // Sum and saturate stage
  always_ff @(posedge clk) begin
    if (en.sum) begin
      c0_r.x <= add_sat(rnd_r.cx0, rnd_r.sy0);
      c0_r.y <= sub_sat(rnd_r.cy0, rnd_r.sx0);
      c1_r.x <= add_sat(rnd_r.cx1, rnd_r.sy0);
      c1_r.y <= sub_sat(rnd_r.cy0, rnd_r.sx1);
      c2_r.x <= add_sat(rnd_r.cx1, rnd_r.sy1);
      c2_r.y <= sub_sat(rnd_r.cy1, rnd_r.sx1);
      c3_r.x <= add_sat(rnd_r.cx0, rnd_r.sy1);
      c3_r.y <= sub_sat(rnd_r.cy1, rnd_r.sx0);
    end
  end

  assign c0_o = c0_r;
  assign c1_o = c1_r;
  assign c2_o = c2_r;
  assign c3_o = c3_r;

endmodule

>>> design/segment_rotated_bounding_box_top.sv
// Oriented bounding box of one trace segment.
// Input channel (in_valid / in_stall / in_data): one segment per request with
// its endpoints, alignment angle, view angle and left/right widths.
// Output channel (out_valid / out_stall / out_data): the four box corners,
// rotated by minus the view angle, one result per input request.
// A request accepted into stage 1 moves through the stage registers to
// out_valid and is taken when the receiver does not stall. Throughput:
// one request per cycle while in_stall is low, set by the 8-stage pipeline
// (trig lookup, align multiply, round, sum, box edges, view multiply, round,
// sum); both rotations use their own multiplier bank and the sine/cosine come
// from a 91-entry constant table.
// Stall: each stage holds while it is full and the stage after it holds, so
// bubbles close up; in_stall rises only when all 8 stages hold results and
// out_stall is high. A held result stays unchanged on out_data.
// Reset: synchronous, active low; it empties the pipeline. There is no
// configuration and no stored state between requests.
module segment_rotated_bounding_box_top import srbb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef struct packed {
    logic [WIDTH_BITS-1:0]   lw;
    logic [WIDTH_BITS-1:0]   rw;
    logic signed [SIN_W-1:0] sv;
    logic signed [SIN_W-1:0] cv;
  } side_t;

  logic [PIPE_DEPTH:1] v_r;
  logic [PIPE_DEPTH:1] en;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || !out_stall;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[PIPE_DEPTH];

  // Stage 1: sine/cosine lookup
  logic signed [SIN_W-1:0] sa;
  logic signed [SIN_W-1:0] ca;
  logic signed [SIN_W-1:0] sv;
  logic signed [SIN_W-1:0] cv;

  srbb_trig u_trig_align (
    .angle_i (in_data.align_angle),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  srbb_trig u_trig_view (
    .angle_i (in_data.view_angle),
    .sin_o   (sv),
    .cos_o   (cv)
  );

  point_t                  s1_p0_r;
  point_t                  s1_p1_r;
  logic signed [SIN_W-1:0] s1_sa_r;
  logic signed [SIN_W-1:0] s1_ca_r;
  side_t                   sb_r [1:4];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_p0_r.x   <= in_data.start_x;
      s1_p0_r.y   <= in_data.start_y;
      s1_p1_r.x   <= in_data.end_x;
      s1_p1_r.y   <= in_data.end_y;
      s1_sa_r     <= sa;
      s1_ca_r     <= ca;
    end
  end

  // Stages 2-4: rotate both endpoints by minus the alignment angle
  rot_en_t en_a;
  point_t  pa0;
  point_t  pa1;

  assign en_a.mul = en[2];
  assign en_a.rnd = en[3];
  assign en_a.sum = en[4];

  srbb_rot u_rot_align (
    .clk   (clk),
    .en    (en_a),
    .p0_i  (s1_p0_r),
    .p1_i  (s1_p1_r),
    .sin_i (s1_sa_r),
    .cos_i (s1_ca_r),
    .c0_o  (pa0),
    .c1_o  (),
    .c2_o  (pa1),
    .c3_o  ()
  );

  // Side data follows the rotation unit
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sb_r[1].lw  <= in_data.left_width;
      sb_r[1].rw  <= in_data.right_width;
      sb_r[1].sv  <= sv;
      sb_r[1].cv  <= cv;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // Stage 5: bottom and top edges
  point_t                  e_p0_r;
  point_t                  e_p1_r;
  logic signed [SIN_W-1:0] e_sv_r;
  logic signed [SIN_W-1:0] e_cv_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      e_p0_r.x <= pa0.x;
      e_p0_r.y <= sat_coord(SUM_W'(pa0.y) - SUM_W'(signed'({1'b0, sb_r[4].rw})));
      e_p1_r.x <= pa1.x;
      e_p1_r.y <= sat_coord(SUM_W'(pa1.y) + SUM_W'(signed'({1'b0, sb_r[4].lw})));
      e_sv_r   <= sb_r[4].sv;
      e_cv_r   <= sb_r[4].cv;
    end
  end

  // Stages 6-8: rotate the four corners by minus the view angle;
  // a zero view angle gives cos = 1, sin = 0, which passes corners exactly
  rot_en_t en_v;
  point_t  pv0;
  point_t  pv1;
  point_t  pv2;
  point_t  pv3;

  assign en_v.mul = en[6];
  assign en_v.rnd = en[7];
  assign en_v.sum = en[8];

  srbb_rot u_rot_view (
    .clk   (clk),
    .en    (en_v),
    .p0_i  (e_p0_r),
    .p1_i  (e_p1_r),
    .sin_i (e_sv_r),
    .cos_i (e_cv_r),
    .c0_o  (pv0),
    .c1_o  (pv1),
    .c2_o  (pv2),
    .c3_o  (pv3)
  );

  always_comb begin
    out_data.corner0_x = pv0.x;
    out_data.corner0_y = pv0.y;
    out_data.corner1_x = pv1.x;
    out_data.corner1_y = pv1.y;
    out_data.corner2_x = pv2.x;
    out_data.corner2_y = pv2.y;
    out_data.corner3_x = pv3.x;
    out_data.corner3_y = pv3.y;
  end

endmodule

>>> design/srbb_checker.sv
module srbb_checker import srbb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIPE_DEPTH);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Requests in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A held result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  // Never more requests in flight than pipeline stages
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("more requests in flight than stages");

  // Nothing in flight means nothing to deliver
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !out_valid)
    else $error("result without a request");

  // Input backs up only when the pipeline is full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> cnt_r == CNT_FULL && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

bind segment_rotated_bounding_box_top srbb_checker u_srbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
